@@ design/double_ended_queue_unit_assert.svh @@
// Assertion macros for the double-ended queue unit.
// Both expect signals named clock and reset in the scope where they are used.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define DEQ_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deque assertion failed");

// next-cycle implication
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deque assertion failed");

`endif

@@ design/deq_pkg.sv @@
`default_nettype none
package deq_pkg;

   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_PUSH_BACK  = 3'd1,
      REQ_POP_FRONT  = 3'd2,
      REQ_POP_BACK   = 3'd3,
      REQ_PEEK_FRONT = 3'd4,
      REQ_PEEK_BACK  = 3'd5,
      REQ_CLEAR      = 3'd6
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic latch_req;   // capture request word
      logic exec;        // run the operation, touch the store
   } deq_cmd_type;

endpackage
`default_nettype wire

@@ design/deq_req_if.sv @@
`default_nettype none
interface deq_req_if import deq_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [KIND_W-1:0]          req_type;
   logic signed [VALUE_W-1:0]  push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);
endinterface
`default_nettype wire

@@ design/deq_rsp_if.sv @@
`default_nettype none
interface deq_rsp_if import deq_pkg::*; #(
   parameter int COUNT_W = 11
) ();
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  read_value;
   logic [STATUS_W-1:0]        status;
   logic [COUNT_W-1:0]         item_count;
   logic                       is_empty;

   modport source (output valid, output read_value, output status, output item_count,
                   output is_empty, input ready);
   modport sink   (input valid, input read_value, input status, input item_count,
                   input is_empty, output ready);
endinterface
`default_nettype wire

@@ design/deq_ctrl.sv @@
`default_nettype none
module deq_ctrl import deq_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output deq_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == S_IDLE);
      rsp_valid     = (state_ff == S_RESP);
      cmd.latch_req = (state_ff == S_IDLE) && req_valid;
      cmd.exec      = (state_ff == S_EXEC);
   end

endmodule
`default_nettype wire

@@ design/deq_datapath.sv @@
`default_nettype none
module deq_datapath import deq_pkg::*; #(
   parameter int DEPTH   = 1024,
   parameter int ADDR_W  = $clog2(DEPTH),
   parameter int COUNT_W = $clog2(DEPTH + 1)
) (
   input  wire                        clock,
   input  wire                        reset,
   input  deq_cmd_type                cmd,
   input  wire  [KIND_W-1:0]          req_type,
   input  wire  signed [VALUE_W-1:0]  push_value,
   output logic signed [VALUE_W-1:0]  read_value,
   output logic [STATUS_W-1:0]        status,
   output logic [COUNT_W-1:0]         item_count,
   output logic                       is_empty
);

   localparam int SUM_W = COUNT_W + 1;

   logic signed [VALUE_W-1:0] mem [DEPTH];

   req_kind_type              kind_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [ADDR_W-1:0]         front_ff, front_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   status_type                status_ff, status_in;
   logic                      read_ok_ff, read_ok_in;
   logic signed [VALUE_W-1:0] rdata_ff;

   logic                      full, empty, wr_en, rd_en;
   logic [ADDR_W-1:0]         addr, front_dec, front_inc, back_new, back_last;
   logic [SUM_W-1:0]          sum_new, sum_last;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         kind_ff  <= req_kind_type'(req_type);
         value_ff <= push_value;
      end
   end

   assign full  = (count_ff == COUNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   assign front_dec = (front_ff == '0) ? ADDR_W'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == ADDR_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;

   // ring positions: sums stay below twice the depth, one subtract wraps them
   assign sum_new  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign sum_last = sum_new - 1'b1;
   assign back_new  = (sum_new  >= SUM_W'(DEPTH)) ? ADDR_W'(sum_new  - SUM_W'(DEPTH))
                                                  : ADDR_W'(sum_new);
   assign back_last = (sum_last >= SUM_W'(DEPTH)) ? ADDR_W'(sum_last - SUM_W'(DEPTH))
                                                  : ADDR_W'(sum_last);

   always_comb begin
      front_in   = front_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      read_ok_in = read_ok_ff;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      addr       = front_ff;
      if (cmd.exec) begin
         status_in  = ST_OK;
         read_ok_in = 1'b0;
         unique case (kind_ff)
            REQ_PUSH_FRONT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  addr     = front_dec;
                  front_in = front_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            REQ_PUSH_BACK: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  addr     = back_new;
                  count_in = count_ff + 1'b1;
               end
            end
            REQ_POP_FRONT, REQ_PEEK_FRONT: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en      = 1'b1;
                  read_ok_in = 1'b1;
                  addr       = front_ff;
                  if (kind_ff == REQ_POP_FRONT) begin
                     front_in = front_inc;
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            REQ_POP_BACK, REQ_PEEK_BACK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en      = 1'b1;
                  read_ok_in = 1'b1;
                  addr       = back_last;
                  if (kind_ff == REQ_POP_BACK) count_in = count_ff - 1'b1;
               end
            end
            REQ_CLEAR: begin
               front_in = '0;
               count_in = '0;
            end
            default: begin
               // unused code: nothing changes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      read_ok_ff <= read_ok_in;
   end

   // value store, one port
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= value_ff;
      if (rd_en) rdata_ff <= mem[addr];
   end

   assign read_value = read_ok_ff ? rdata_ff : '0;
   assign status     = status_ff;
   assign item_count = count_ff;
   assign is_empty   = (count_ff == '0);

endmodule
`default_nettype wire

@@ design/double_ended_queue_unit.sv @@
//  channel   dir   handshake      word
//  req_if    in    valid/ready    req_type[2:0], push_value[31:0] signed
//  rsp_if    out   valid/ready    read_value[31:0] signed, status[1:0],
//                                 item_count[$clog2(DEPTH+1)-1:0], is_empty
//
//  Each request runs through accept, execute (single store access plus
//  pointer update) and response held, in that order.
//  The value store is single-port with registered read data.
//  Synchronous active-high reset empties the queue; the store itself is not
//  cleared, entries are only read after a push wrote them.
//  A stalled response holds its word and blocks the next request.
`default_nettype none
module double_ended_queue_unit import deq_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  wire        clock,
   input  wire        reset,
   deq_req_if.sink    req_if,
   deq_rsp_if.source  rsp_if     // COUNT_W of the instance must be $clog2(DEPTH+1)
);

   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   deq_cmd_type cmd;

   // sequencing: idle -> execute -> respond
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   // ring store, head index and count
   deq_datapath #(
      .DEPTH   (DEPTH),
      .ADDR_W  (ADDR_W),
      .COUNT_W (COUNT_W)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_type   (req_if.req_type),
      .push_value (req_if.push_value),
      .read_value (rsp_if.read_value),
      .status     (rsp_if.status),
      .item_count (rsp_if.item_count),
      .is_empty   (rsp_if.is_empty)
   );

endmodule
`default_nettype wire

@@ design/deq_checker.sv @@
`default_nettype none
`include "double_ended_queue_unit_assert.svh"
module deq_checker import deq_pkg::*; (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_ready,
   input wire                       rsp_valid,
   input wire                       rsp_ready,
   input wire signed [VALUE_W-1:0]  read_value,
   input wire [STATUS_W-1:0]        status,
   input wire                       count_zero,
   input wire                       is_empty
);

   // one request in flight: no accept while a response waits
   `DEQ_ASSERT_NOW(a_one_in_flight, rsp_valid, !req_ready)

   // stalled response keeps its word
   `DEQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(read_value))

   // empty flag agrees with the count
   `DEQ_ASSERT_NOW(a_empty_flag, rsp_valid, is_empty == count_zero)

   // a failed pop or peek reads nothing from an empty queue
   `DEQ_ASSERT_NOW(a_empty_status, rsp_valid && status == ST_EMPTY,
                   is_empty && read_value == '0)

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .read_value (rsp_if.read_value),
   .status     (rsp_if.status),
   .count_zero (rsp_if.item_count == '0),
   .is_empty   (rsp_if.is_empty)
);
`default_nettype wire
